// ===== sv/lfp_pkg.sv =====
// ============================================================================
// lfp_pkg: shared types and constants of the lamp-fade LED matrix driver
// Matrix geometry, field widths, beat types and register indexes.
// ============================================================================
package lfp_pkg;

    localparam int LED_ROWS   = 8;
    localparam int LED_COLS   = 12;
    localparam int PWM_LEVELS = 32;
    localparam int NLEDS      = LED_ROWS * LED_COLS;
    localparam int ADDR_W     = $clog2(NLEDS);

    localparam int ROW_W      = 3;
    localparam int COL_W      = 4;
    localparam int CNT_W      = 24;
    localparam int DVS_W      = CNT_W - 5;
    localparam int TGT_W      = 8;
    localparam int FRAC_W     = 16;
    localparam int BRT_W      = TGT_W + FRAC_W;
    localparam int ACT_W      = BRT_W + TGT_W;
    localparam int FACTOR_W   = 16;
    localparam int STEP_W     = 6;
    localparam int ROWCNT_W   = $clog2(LED_ROWS + 1);

    localparam logic [FACTOR_W-1:0] RISE_RESET = 16'd786;
    localparam logic [FACTOR_W-1:0] FALL_RESET = 16'd328;

    localparam logic REG_RISE = 1'b0;
    localparam logic REG_FALL = 1'b1;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [ROW_W-1:0] FORCE_ROW   = 3'd5;
    localparam logic [COL_W-1:0] FORCE_COL_A = 4'd2;
    localparam logic [COL_W-1:0] FORCE_COL_B = 4'd3;
    localparam logic [TGT_W-1:0] FORCE_LEVEL = TGT_W'(PWM_LEVELS / 2);

    typedef struct packed {
        logic             req_type;
        logic [ROW_W-1:0] led_row;
        logic [COL_W-1:0] led_col;
        logic [CNT_W-1:0] on_count;
        logic [CNT_W-1:0] instr_total;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]    row_index;
        logic [LED_COLS-1:0] column_drive;
        logic [STEP_W-1:0]   pwm_step;
        logic                frame_restart;
        logic                last_row;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [TGT_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== sv/lfp_ram.sv =====
// ============================================================================
// lfp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ============================================================================
module lfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/lfp_div.sv =====
// ============================================================================
// lfp_div: saturating restoring divider for the LED target
// A saturation check first, then one quotient bit per cycle, 8 bits max.
// ============================================================================
module lfp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfp_pkg::t_div_req i_req,
    output lfp_pkg::t_div_rsp o_rsp
);

    localparam int SHIFT_W = lfp_pkg::DVS_W + lfp_pkg::TGT_W;
    localparam int K_W     = $clog2(lfp_pkg::TGT_W);
    localparam logic [K_W-1:0] K_TOP = K_W'(lfp_pkg::TGT_W - 1);

    logic                        r_busy;
    logic                        r_chk;
    logic                        r_done;
    logic [K_W-1:0]              r_k;
    logic [lfp_pkg::CNT_W-1:0]   r_rem;
    logic [lfp_pkg::DVS_W-1:0]   r_dvs;
    logic [lfp_pkg::TGT_W-1:0]   r_quo;

    logic [SHIFT_W-1:0]          w_shift;
    logic                        w_fit;
    logic                        w_sat;

    assign w_shift = SHIFT_W'(r_dvs) << r_k;
    assign w_fit   = SHIFT_W'(r_rem) >= w_shift;
    // quotient above 255 exactly when the divisor fits in the dividend's upper bits
    assign w_sat   = lfp_pkg::DVS_W'(r_rem[lfp_pkg::CNT_W-1:lfp_pkg::TGT_W]) >= r_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_chk  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_chk  <= 1'b1;
            end else if (r_busy && r_chk) begin
                if (w_sat) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_chk <= 1'b0;
                end
            end else if (r_busy && r_k == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_quo <= '0;
            r_k   <= K_TOP;
        end else if (r_busy && r_chk) begin
            if (w_sat) begin
                r_quo <= '1;
            end
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem        <= r_rem - w_shift[lfp_pkg::CNT_W-1:0];
                r_quo[r_k]   <= 1'b1;
            end
            r_k <= r_k - K_W'(1);
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== sv/lamp_fade_pwm_led_matrix_unit.sv =====
// ============================================================================
// lamp_fade_pwm_led_matrix_unit: lamp-fade PWM driver for an LED matrix
// Load beats set pending LED targets; tick beats fade every LED and emit
// one column mask per row.
// ============================================================================
// A load beat runs through a saturating divider, which resolves the
// target with a saturation check and up to 8 quotient bits, then the
// target is written. During a tick beat the input is stalled while the
// brightness memory is swept one LED per cycle through a read, a compare
// and a multiply-accumulate stage. Row results come out as soon as each
// row is finished and drain through an output register; load beats are
// taken while rows still drain, the next tick waits until every row of
// the last one has been handed to the output register, so a stalled
// output side also holds off the next tick.
module lamp_fade_pwm_led_matrix_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lfp_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lfp_pkg::t_out_item o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int ADDR_W = lfp_pkg::ADDR_W;
    localparam int ROW_W  = lfp_pkg::ROW_W;
    localparam int COL_W  = lfp_pkg::COL_W;
    localparam int TGT_W  = lfp_pkg::TGT_W;
    localparam int BRT_W  = lfp_pkg::BRT_W;
    localparam int FRAC_W = lfp_pkg::FRAC_W;
    localparam int FCT_W  = lfp_pkg::FACTOR_W;
    localparam int PROD_W = BRT_W + FCT_W;
    localparam int RC_W   = lfp_pkg::ROWCNT_W;
    localparam int STEP_W = lfp_pkg::STEP_W;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(lfp_pkg::NLEDS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(lfp_pkg::LED_COLS - 1);
    localparam logic [RC_W-1:0]   ALL_ROWS  = RC_W'(lfp_pkg::LED_ROWS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SWEEP
    } t_state;

    t_state r_state;

    // configuration
    logic [FCT_W-1:0] r_rise;
    logic [FCT_W-1:0] r_fall;
    logic             w_cfg_wr;

    // input side
    logic                       w_in_acc;
    logic                       w_tick_acc;
    logic                       w_load_ok;
    logic                       w_out_busy;
    logic [lfp_pkg::DVS_W-1:0]  w_dvs_raw;
    logic [ADDR_W-1:0]          w_load_addr;
    logic [ADDR_W-1:0]          r_ld_addr;
    lfp_pkg::t_div_req          w_div_req;
    lfp_pkg::t_div_rsp          w_div_rsp;

    logic [STEP_W-1:0] r_pwm;
    logic              r_restart;
    logic              w_restart;

    // sweep pipeline
    logic              r_rd_on;
    logic [ADDR_W-1:0] r_rd_addr;
    logic [ROW_W-1:0]  r_rd_row;
    logic [COL_W-1:0]  r_rd_col;

    logic              r_s1_v;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [ROW_W-1:0]  r_s1_row;
    logic [COL_W-1:0]  r_s1_col;
    logic              r_s1_avld;
    logic              r_s1_pvld;

    logic              r_s2_v;
    logic [ADDR_W-1:0] r_s2_addr;
    logic [ROW_W-1:0]  r_s2_row;
    logic [COL_W-1:0]  r_s2_col;
    logic [BRT_W-1:0]  r_s2_b;
    logic [TGT_W-1:0]  r_s2_tgt;
    logic [BRT_W-1:0]  r_s2_d;
    logic [FCT_W-1:0]  r_s2_f;
    logic              r_s2_rise;

    logic [lfp_pkg::NLEDS-1:0] r_a_vld;
    logic [lfp_pkg::NLEDS-1:0] r_p_vld;

    logic [lfp_pkg::ACT_W-1:0] w_a_dout;
    logic [TGT_W-1:0]          w_p_dout;

    logic [BRT_W-1:0]  w_s1_b;
    logic [TGT_W-1:0]  w_s1_aold;
    logic [TGT_W-1:0]  w_s1_p;
    logic              w_s1_forced;
    logic [TGT_W-1:0]  w_s1_tgt;
    logic [BRT_W-1:0]  w_s1_t;
    logic              w_s1_rise;

    logic [PROD_W-1:0] w_prod;
    logic [BRT_W-1:0]  w_step_amt;
    logic [BRT_W-1:0]  w_b_new;
    logic              w_lit;

    // row masks and output
    logic [lfp_pkg::LED_COLS-1:0] r_mask_acc;
    logic [lfp_pkg::LED_COLS-1:0] w_row_mask;
    logic [lfp_pkg::LED_COLS-1:0] r_masks [lfp_pkg::LED_ROWS];
    logic [RC_W-1:0]              r_rows_done;
    logic [RC_W-1:0]              r_out_row;
    logic                         w_out_load;
    logic                         r_out_valid;
    lfp_pkg::t_out_item           r_out;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise <= lfp_pkg::RISE_RESET;
            r_fall <= lfp_pkg::FALL_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == lfp_pkg::REG_RISE) begin
                r_rise <= pwdata[FCT_W-1:0];
            end else begin
                r_fall <= pwdata[FCT_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            prdata = (paddr[2] == lfp_pkg::REG_FALL) ? 32'(r_fall) : 32'(r_rise);
        end
    end

    // ------------------------------------------------------------------
    // input handshake and load path
    // ------------------------------------------------------------------
    assign w_out_busy = r_out_row != ALL_ROWS;
    assign o_in_stall = (r_state != ST_IDLE) ||
                        (i_in.req_type == lfp_pkg::REQ_TICK && w_out_busy);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_tick_acc = w_in_acc && i_in.req_type == lfp_pkg::REQ_TICK;

    assign w_load_ok  = ({1'b0, i_in.led_row} < (ROW_W + 1)'(lfp_pkg::LED_ROWS)) &&
                        ({1'b0, i_in.led_col} < (COL_W + 1)'(lfp_pkg::LED_COLS));
    assign w_dvs_raw  = i_in.instr_total[lfp_pkg::CNT_W-1:5];
    assign w_load_addr = ADDR_W'(i_in.led_row * lfp_pkg::LED_COLS + i_in.led_col);

    assign w_div_req.start    = w_in_acc && i_in.req_type == lfp_pkg::REQ_LOAD && w_load_ok;
    assign w_div_req.dividend = i_in.on_count;
    assign w_div_req.divisor  = (w_dvs_raw == '0) ? lfp_pkg::DVS_W'(1) : w_dvs_raw;

    always_ff @(posedge i_clk) begin
        if (w_div_req.start) begin
            r_ld_addr <= w_load_addr;
        end
    end

    lfp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------
    // PWM step
    // ------------------------------------------------------------------
    assign w_restart = r_pwm >= STEP_W'(lfp_pkg::PWM_LEVELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm     <= STEP_W'(lfp_pkg::PWM_LEVELS);
            r_restart <= 1'b0;
        end else if (w_tick_acc) begin
            r_pwm     <= w_restart ? STEP_W'(1) : r_pwm + STEP_W'(1);
            r_restart <= w_restart;
        end
    end

    // ------------------------------------------------------------------
    // state machine and read issue
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_on   <= 1'b0;
            r_rd_addr <= '0;
            r_rd_row  <= '0;
            r_rd_col  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_tick_acc) begin
                        r_state   <= ST_SWEEP;
                        r_rd_on   <= 1'b1;
                        r_rd_addr <= '0;
                        r_rd_row  <= '0;
                        r_rd_col  <= '0;
                    end else if (w_div_req.start) begin
                        r_state <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE: begin
                    if (w_div_rsp.done) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SWEEP: begin
                    if (r_rd_on) begin
                        r_rd_addr <= r_rd_addr + ADDR_W'(1);
                        if (r_rd_col == LAST_COL) begin
                            r_rd_col <= '0;
                            r_rd_row <= r_rd_row + ROW_W'(1);
                        end else begin
                            r_rd_col <= r_rd_col + COL_W'(1);
                        end
                        if (r_rd_addr == LAST_ADDR) begin
                            r_rd_on <= 1'b0;
                        end
                    end
                    // finish once the last LED has been written back
                    if (r_s2_v && r_s2_addr == LAST_ADDR) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_rd_on <= 1'b0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // memories: brightness with active target, and pending target
    // ------------------------------------------------------------------
    lfp_ram #(
        .WIDTH (lfp_pkg::ACT_W),
        .DEPTH (lfp_pkg::NLEDS)
    ) u_act_ram (
        .i_clk   (i_clk),
        .i_we    (r_s2_v),
        .i_waddr (r_s2_addr),
        .i_wdata ({w_b_new, r_s2_tgt}),
        .i_re    (r_rd_on),
        .i_raddr (r_rd_addr),
        .o_rdata (w_a_dout)
    );

    lfp_ram #(
        .WIDTH (TGT_W),
        .DEPTH (lfp_pkg::NLEDS)
    ) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (w_div_rsp.done),
        .i_waddr (r_ld_addr),
        .i_wdata (w_div_rsp.quotient),
        .i_re    (r_rd_on),
        .i_raddr (r_rd_addr),
        .o_rdata (w_p_dout)
    );

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= '0;
            r_p_vld <= '0;
        end else begin
            if (r_s2_v) begin
                r_a_vld[r_s2_addr] <= 1'b1;
            end
            if (w_div_rsp.done) begin
                r_p_vld[r_ld_addr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: pick target, choose rise or fall operands
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= r_rd_on;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_on) begin
            r_s1_addr <= r_rd_addr;
            r_s1_row  <= r_rd_row;
            r_s1_col  <= r_rd_col;
            r_s1_avld <= r_a_vld[r_rd_addr];
            r_s1_pvld <= r_p_vld[r_rd_addr];
        end
    end

    assign w_s1_b      = r_s1_avld ? w_a_dout[lfp_pkg::ACT_W-1:TGT_W] : '0;
    assign w_s1_aold   = r_s1_avld ? w_a_dout[TGT_W-1:0] : '0;
    assign w_s1_p      = r_s1_pvld ? w_p_dout : '0;
    assign w_s1_forced = r_s1_row == lfp_pkg::FORCE_ROW &&
                         (r_s1_col == lfp_pkg::FORCE_COL_A || r_s1_col == lfp_pkg::FORCE_COL_B);
    // a restarting tick takes the pending targets as it goes, except the forced LEDs, which take FORCE_LEVEL
    assign w_s1_tgt    = r_restart ? (w_s1_forced ? lfp_pkg::FORCE_LEVEL : w_s1_p) : w_s1_aold;
    assign w_s1_t      = {w_s1_tgt, {FRAC_W{1'b0}}};
    assign w_s1_rise   = w_s1_b <= w_s1_t;

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_s2_addr <= r_s1_addr;
            r_s2_row  <= r_s1_row;
            r_s2_col  <= r_s1_col;
            r_s2_b    <= w_s1_b;
            r_s2_tgt  <= w_s1_tgt;
            r_s2_d    <= w_s1_rise ? w_s1_t - w_s1_b : w_s1_b;
            r_s2_f    <= w_s1_rise ? r_rise : r_fall;
            r_s2_rise <= w_s1_rise;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: scale, apply, write back, collect the row mask
    // ------------------------------------------------------------------
    assign w_prod     = PROD_W'(r_s2_d) * PROD_W'(r_s2_f);
    assign w_step_amt = w_prod[PROD_W-1:FRAC_W];
    assign w_b_new    = r_s2_rise ? r_s2_b + w_step_amt : r_s2_b - w_step_amt;
    assign w_lit      = w_b_new[BRT_W-1:FRAC_W] >= TGT_W'(r_pwm);

    always_comb begin
        w_row_mask             = r_mask_acc;
        w_row_mask[r_s2_col]   = w_lit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_acc <= '0;
        end else if (r_s2_v) begin
            r_mask_acc <= (r_s2_col == LAST_COL) ? '0 : w_row_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v && r_s2_col == LAST_COL) begin
            r_masks[r_s2_row] <= w_row_mask;
        end
    end

    // ------------------------------------------------------------------
    // output register, drained row by row
    // ------------------------------------------------------------------
    assign w_out_load = (r_out_row < r_rows_done) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_done <= ALL_ROWS;
            r_out_row   <= ALL_ROWS;
            r_out_valid <= 1'b0;
        end else begin
            if (w_tick_acc) begin
                r_rows_done <= '0;
                r_out_row   <= '0;
            end else begin
                if (r_s2_v && r_s2_col == LAST_COL) begin
                    r_rows_done <= r_rows_done + RC_W'(1);
                end
                if (w_out_load) begin
                    r_out_row <= r_out_row + RC_W'(1);
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.row_index     <= r_out_row[ROW_W-1:0];
            r_out.column_drive  <= r_masks[r_out_row[ROW_W-1:0]];
            r_out.pwm_step      <= r_pwm;
            r_out.frame_restart <= r_restart;
            r_out.last_row      <= r_out_row == ALL_ROWS - RC_W'(1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== sv/lfp_chk.sv =====
// ============================================================================
// lfp_chk: port-level checker for the lamp-fade LED matrix driver
// Watches beats on both channels; attached to the top level by bind.
// ============================================================================
module lfp_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input lfp_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lfp_pkg::t_out_item o_out
);

    logic w_tick_beat;

    assign w_tick_beat = i_in_valid && !o_in_stall && i_in.req_type == lfp_pkg::REQ_TICK;

    // a tick occupies the block on the following cycle
    a_tick_holds_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick_beat |=> o_in_stall)
        else $error("input taken right after a tick beat");

    // no new tick while a row other than the last one of the previous tick is held at the output
    a_no_tick_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.last_row) |-> !w_tick_beat)
        else $error("tick beat accepted before all rows were delivered");

    // a restarting frame always runs at the first step
    a_restart_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.frame_restart) |-> o_out.pwm_step == lfp_pkg::STEP_W'(1))
        else $error("frame restart on a step other than the first");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled output beat changed or dropped");

endmodule

bind lamp_fade_pwm_led_matrix_unit lfp_chk u_lfp_chk (.*);
